[rtl/cnct_pkg.sv]
// package with the payload words, codes and state type of the network classifier table
`default_nettype none

package cnct_pkg;

  // mode codes of an input word
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // status codes of a result word
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // input word
  typedef struct packed {
    logic        mode;
    logic [31:0] lookup_addr;
    logic [31:0] new_network;
    logic [31:0] new_mask;
    logic [31:0] new_masquerade;
  } cnct_req_t;

  // result word
  typedef struct packed {
    logic        status;
    logic        hit;
    logic [3:0]  match_index;
    logic [31:0] match_network;
    logic [31:0] match_mask;
    logic [31:0] match_masquerade;
  } cnct_rsp_t;

  // one stored table entry
  typedef struct packed {
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] masq;
  } cnct_entry_t;

  // memory port strobes from the sequencer
  typedef struct packed {
    logic we;
    logic re;
  } cnct_mem_ctl_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } cnct_state_t;

endpackage

`default_nettype wire

[rtl/cnct_store.sv]
// entry memory: one write port, one registered read port
`default_nettype none

module cnct_store
  import cnct_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire cnct_mem_ctl_t ctl,
  input  wire logic [AW-1:0] waddr,
  input  wire cnct_entry_t   wdata,
  input  wire logic [AW-1:0] raddr,
  output cnct_entry_t        rdata
);

  cnct_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/cnct_match.sv]
// shared prefix compare unit: address against one entry under its mask
`default_nettype none

module cnct_match
  import cnct_pkg::*;
(
  input  wire logic [31:0] addr,
  input  wire cnct_entry_t entry,
  output logic             hit
);

  // bits that differ, kept only where the mask is set
  logic [31:0] diff;

  always_comb begin
    diff = (addr ^ entry.net) & entry.mask;
    hit  = (diff == 32'd0);
  end

endmodule

`default_nettype wire

[rtl/cidr_network_classifier_table_unit.sv]
// top level of the cidr first-match network table: sequencer, entry memory and compare unit
//
//  channel  | ports           | handshake
//  ---------+-----------------+-------------------------------------------
//  input    | start, req      | word taken at an edge with start=1, busy=0
//  result   | done, rsp       | word valid for one cycle while done=1
//
// an add word's result is registered at the edge that takes it.
// a lookup streams one entry per cycle through the memory read port and the
// compare unit and answers on the first hit, or with a miss after the last entry;
// an empty table answers a lookup from idle, without a scan.
// rst (synchronous) empties the table; entry contents are not cleared.
// busy stays high while a lookup scans; the receiver cannot stall results.
`default_nettype none

module cidr_network_classifier_table_unit
  import cnct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire cnct_req_t req,
  output logic           busy,
  output logic           done,
  output cnct_rsp_t      rsp
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  cnct_state_t   state, state_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [CW-1:0] rd_ptr, rd_ptr_next;
  logic          rd_vld, rd_vld_next;
  logic [IW-1:0] cmp_idx, cmp_idx_next;
  logic [31:0]   key, key_next;
  logic          done_next;
  cnct_rsp_t     rsp_next;

  cnct_mem_ctl_t mem_ctl;
  cnct_entry_t   wr_entry;
  cnct_entry_t   rd_entry;
  logic          match_hit;
  logic          accept;
  logic          table_full;
  logic          last_entry;
  logic [IW+3:0] idx_wide;

  // entry memory
  cnct_store #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (entry_count[IW-1:0]),
    .wdata (wr_entry),
    .raddr (rd_ptr[IW-1:0]),
    .rdata (rd_entry)
  );

  // shared compare unit
  cnct_match u_match (
    .addr  (key),
    .entry (rd_entry),
    .hit   (match_hit)
  );

  // handshake and table status
  always_comb begin
    busy       = (state != ST_IDLE);
    accept     = start && !busy;
    table_full = (entry_count == CW'(TABLE_ENTRIES));
    last_entry = (CW'(CW'(cmp_idx) + CW'(1)) == entry_count);
    idx_wide   = {4'd0, cmp_idx};
    wr_entry   = '{net: req.new_network, mask: req.new_mask, masq: req.new_masquerade};
  end

  // sequencer: next state and outputs
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    rd_ptr_next      = rd_ptr;
    rd_vld_next      = 1'b0;
    cmp_idx_next     = cmp_idx;
    key_next         = key;
    done_next        = 1'b0;
    rsp_next         = rsp;
    mem_ctl          = '{we: 1'b0, re: 1'b0};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          done_next = 1'b0;
          rsp_next  = '0;
          if (req.mode == MODE_ADD) begin
            done_next = 1'b1;
            if (table_full) begin
              rsp_next.status = STATUS_FULL;
            end else begin
              mem_ctl.we       = 1'b1;
              entry_count_next = CW'(entry_count + CW'(1));
              rsp_next.status  = STATUS_OK;
            end
          end else begin
            key_next    = req.lookup_addr;
            rd_ptr_next = '0;
            if (entry_count == '0) begin
              done_next = 1'b1;
            end else begin
              state_next = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // issue the next read while the previous entry is compared
        if (rd_ptr < entry_count) begin
          mem_ctl.re   = 1'b1;
          rd_vld_next  = 1'b1;
          cmp_idx_next = rd_ptr[IW-1:0];
          rd_ptr_next  = CW'(rd_ptr + CW'(1));
        end
        // judge the entry read last cycle
        if (rd_vld) begin
          if (match_hit) begin
            state_next                = ST_IDLE;
            rd_vld_next               = 1'b0;
            done_next                 = 1'b1;
            rsp_next                  = '0;
            rsp_next.hit              = 1'b1;
            rsp_next.match_index      = idx_wide[3:0];
            rsp_next.match_network    = rd_entry.net;
            rsp_next.match_mask       = rd_entry.mask;
            rsp_next.match_masquerade = rd_entry.masq;
          end else if (last_entry) begin
            state_next  = ST_IDLE;
            rd_vld_next = 1'b0;
            done_next   = 1'b1;
            rsp_next    = '0;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      rd_vld      <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      rd_vld      <= rd_vld_next;
      done        <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ptr  <= rd_ptr_next;
    cmp_idx <= cmp_idx_next;
    key     <= key_next;
    rsp     <= rsp_next;
  end

endmodule

`default_nettype wire

[bench/tb_cidr_network_classifier_table_unit.sv]
// testbench for the cidr first-match network table: directed rows, then random words by phase
`timescale 1ns / 1ps

module tb_cidr_network_classifier_table_unit;
  import cnct_pkg::*;

  localparam int TABLE_ENTRIES    = 16;
  localparam int IDLE_CAP         = 64;
  localparam int WATCHDOG         = 1000;
  localparam int RANDOM_PER_PHASE = 444;

  // one row of the directed stimulus table
  typedef struct {
    cnct_req_t w;
    bit        pinned;
    cnct_rsp_t want;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      done;
  cnct_req_t req;
  cnct_rsp_t rsp;

  // shadow copy of the network table
  logic [31:0] tbl_net  [TABLE_ENTRIES];
  logic [31:0] tbl_mask [TABLE_ENTRIES];
  logic [31:0] tbl_masq [TABLE_ENTRIES];
  int          tbl_used;

  cnct_rsp_t owed_answers [$];
  stim_row_t stim_rows [$];
  int        errors = 0;
  int        quiet_cycles = 0;

  cidr_network_classifier_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // first-match classifier: updates the shadow table on add, scans it on lookup
  function automatic cnct_rsp_t classify_word(cnct_req_t w);
    cnct_rsp_t r;
    bit        found;
    r = '0;
    found = 1'b0;
    if (w.mode == MODE_ADD) begin
      if (tbl_used < TABLE_ENTRIES) begin
        tbl_net[tbl_used]  = w.new_network;
        tbl_mask[tbl_used] = w.new_mask;
        tbl_masq[tbl_used] = w.new_masquerade;
        tbl_used++;
      end else begin
        r.status = STATUS_FULL;
      end
    end else begin
      for (int k = 0; k < tbl_used; k++) begin
        if (!found && ((w.lookup_addr ^ tbl_net[k]) & tbl_mask[k]) == 32'h0) begin
          found              = 1'b1;
          r.hit              = 1'b1;
          r.match_index      = k[3:0];
          r.match_network    = tbl_net[k];
          r.match_mask       = tbl_mask[k];
          r.match_masquerade = tbl_masq[k];
        end
      end
    end
    return r;
  endfunction

  // fully random word, used as noise and as the base of random stimulus
  function automatic cnct_req_t noise_word();
    cnct_req_t w;
    w.mode           = 1'($urandom_range(1));
    w.lookup_addr    = $urandom;
    w.new_network    = $urandom;
    w.new_mask       = $urandom;
    w.new_masquerade = $urandom;
    return w;
  endfunction

  function automatic cnct_req_t mk_add(logic [31:0] net, logic [31:0] mask, logic [31:0] masq);
    cnct_req_t w;
    w                = noise_word();
    w.mode           = MODE_ADD;
    w.new_network    = net;
    w.new_mask       = mask;
    w.new_masquerade = masq;
    return w;
  endfunction

  function automatic cnct_req_t mk_look(logic [31:0] addr);
    cnct_req_t w;
    w             = noise_word();
    w.mode        = MODE_LOOKUP;
    w.lookup_addr = addr;
    return w;
  endfunction

  function automatic cnct_rsp_t mk_rsp(logic status, logic hit, logic [3:0] idx,
                                       logic [31:0] net, logic [31:0] mask,
                                       logic [31:0] masq);
    cnct_rsp_t r;
    r.status           = status;
    r.hit              = hit;
    r.match_index      = idx;
    r.match_network    = net;
    r.match_mask       = mask;
    r.match_masquerade = masq;
    return r;
  endfunction

  task automatic add_row(cnct_req_t w, bit pinned, cnct_rsp_t want);
    stim_row_t row;
    row.w      = w;
    row.pinned = pinned;
    row.want   = want;
    stim_rows.push_back(row);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
    $display("%0t mismatch %s: got %h, want %h", $time, what, got_v, want_v);
    errors++;
  endtask

  // present one word, hold it until taken, and log the answer it owes
  task automatic send_word(cnct_req_t w, bit pinned, cnct_rsp_t want, int idle_pct);
    cnct_rsp_t predicted;
    int        gap;
    gap = 0;
    while (gap < IDLE_CAP && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      req   = noise_word();
      @(negedge clk);
      gap++;
    end
    start = 1'b1;
    req   = w;
    do @(posedge clk); while (busy);
    predicted = classify_word(w);
    owed_answers.push_back(pinned ? want : predicted);
    @(negedge clk);
  endtask

  // sender holds off until every owed answer has come back
  task automatic wait_drained();
    start = 1'b0;
    while (owed_answers.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // compare a result word against the oldest owed answer
  task automatic check_answer(cnct_rsp_t got);
    cnct_rsp_t want;
    if (owed_answers.size() == 0) begin
      report_mismatch("result word with nothing owed", got.match_network, 32'h0);
    end else begin
      want = owed_answers.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.hit !== want.hit)
        report_mismatch("hit", 32'(got.hit), 32'(want.hit));
      if (got.match_index !== want.match_index)
        report_mismatch("match_index", 32'(got.match_index), 32'(want.match_index));
      if (got.match_network !== want.match_network)
        report_mismatch("match_network", got.match_network, want.match_network);
      if (got.match_mask !== want.match_mask)
        report_mismatch("match_mask", got.match_mask, want.match_mask);
      if (got.match_masquerade !== want.match_masquerade)
        report_mismatch("match_masquerade", got.match_masquerade, want.match_masquerade);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) check_answer(rsp);
  end

  // watchdog on cycles with no word taken and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int        idle_pct [4];
    cnct_req_t w;
    int        k;
    int        roll;
    cnct_rsp_t miss;

    rst      = 1'b1;
    start    = 1'b0;
    req      = '0;
    tbl_used = 0;
    idle_pct = '{0, 86, 0, 11};
    miss     = mk_rsp(STATUS_OK, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0);

    // directed rows: empty table, extremes, first-match shadowing, full table
    add_row(mk_look(32'h0000_0000), 1, miss);
    add_row(mk_look(32'hFFFF_FFFF), 1, miss);
    add_row(mk_add(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001), 1, miss);
    add_row(mk_look(32'h0000_0000), 1,
            mk_rsp(STATUS_OK, 1'b1, 4'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001));
    add_row(mk_look(32'hFFFF_FFFF), 1, miss);
    add_row(mk_add(32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0001), 1, miss);
    // narrower prefix inside the one above, never reachable
    add_row(mk_add(32'h0A12_0000, 32'hFFFF_0000, 32'hFFFF_FFFF), 1, miss);
    add_row(mk_look(32'h0A12_3456), 0, miss);
    add_row(mk_add(32'hAC10_0500, 32'hFFFF_FF00, 32'h1234_5678), 1, miss);
    add_row(mk_add(32'hAC10_0000, 32'hFFF0_0000, 32'h8765_4321), 1, miss);
    // network with host bits set
    add_row(mk_add(32'hC0A8_01FF, 32'hFFFF_FF00, 32'h0A0A_0A0A), 1, miss);
    add_row(mk_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, miss);
    // non-contiguous mask
    add_row(mk_add(32'h5A5A_5A5A, 32'h0F0F_0F0F, 32'hA5A5_A5A5), 1, miss);
    add_row(mk_add(32'h6440_0000, 32'hFFC0_0000, 32'h0102_0304), 1, miss);
    add_row(mk_add(32'hE000_0000, 32'hF000_0000, 32'hE000_0001), 1, miss);
    add_row(mk_add(32'h7F00_0000, 32'hFF00_0000, 32'h7F00_0001), 1, miss);
    add_row(mk_add(32'hA9FE_0000, 32'hFFFF_0000, 32'hA9FE_0101), 1, miss);
    add_row(mk_add(32'hC612_0000, 32'hFFFE_0000, 32'hC612_0001), 1, miss);
    add_row(mk_add(32'h8000_0000, 32'h8000_0000, 32'h8000_0001), 1, miss);
    add_row(mk_add(32'h0102_0304, 32'hFFFF_FFFF, 32'h0403_0201), 1, miss);
    // zero mask catches everything left, fills the last slot
    add_row(mk_add(32'h0000_0000, 32'h0000_0000, 32'hDEAD_BEEF), 1, miss);
    add_row(mk_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
            mk_rsp(STATUS_FULL, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0));
    add_row(mk_look(32'hC0A8_0155), 0, miss);
    add_row(mk_look(32'h1234_5678), 0, miss);
    add_row(mk_look(32'hFFFF_FFFF), 0, miss);

    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) send_word(stim_rows[i].w, stim_rows[i].pinned, stim_rows[i].want, 0);

    // random phases: mostly lookups aimed inside a stored prefix
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        w    = noise_word();
        if (roll < 10) begin
          w.mode = MODE_ADD;
        end else begin
          w.mode = MODE_LOOKUP;
          if (roll < 85 && tbl_used > 0) begin
            k = $urandom_range(tbl_used - 1);
            w.lookup_addr = (tbl_net[k] & tbl_mask[k]) | (w.lookup_addr & ~tbl_mask[k]);
          end
        end
        send_word(w, 0, miss, idle_pct[p]);
      end
    end

    wait_drained();
    repeat (TABLE_ENTRIES + 4) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[cidr_network_classifier_table_unit.f]
rtl/cnct_pkg.sv
rtl/cnct_store.sv
rtl/cnct_match.sv
rtl/cidr_network_classifier_table_unit.sv
bench/tb_cidr_network_classifier_table_unit.sv
